>>> src/tun_pkg.sv
package tun_pkg;

    // Default coordinate width (Q8.8) and normal fraction bits (Q1.14)
    localparam int COORD_WIDTH      = 16;
    localparam int NORMAL_FRAC_BITS = 14;

    // Magnitudes are normalised so that the largest lies in [2^30, 2^31)
    localparam int NORM_BITS = 31;

    // Pipeline step control shared by every section
    typedef struct packed {
        logic en;
    } t_ctl;

endpackage

>>> src/tun_if.sv
interface tun_in_if #(
    parameter int CoordWidth = tun_pkg::COORD_WIDTH
) ();
    logic                         valid;
    logic                         ready;
    logic signed [CoordWidth-1:0] a_x, a_y, a_z;
    logic signed [CoordWidth-1:0] b_x, b_y, b_z;
    logic signed [CoordWidth-1:0] c_x, c_y, c_z;

    modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                    input ready);
    modport sink   (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                    output ready);
endinterface

interface tun_out_if #(
    parameter int FracBits = tun_pkg::NORMAL_FRAC_BITS
) ();
    logic                       valid;
    logic                       ready;
    logic signed [FracBits+1:0] normal_x, normal_y, normal_z;
    logic                       degenerate;

    modport source (output valid, normal_x, normal_y, normal_z, degenerate,
                    input ready);
    modport sink   (input valid, normal_x, normal_y, normal_z, degenerate,
                    output ready);
endinterface

>>> src/triangle_unit_normal.sv
// Channel  Dir  Words                                   Handshake
// i_tri    in   a_x..c_z, three vertices, signed Q8.8     valid/ready
// o_nrm    out  normal_x/y/z Q1.14, degenerate flag      valid/ready
//
// One word enters per cycle while the pipe is not held; each word passes through
// the front section, then the bit-per-stage root and divide pipes.
// Reset (i_rst_n, synchronous, active low) clears only the stage valid bits;
// i_tri.ready is held low while reset is asserted.
// The whole pipe steps together: it holds when the output word is valid and
// not taken, and i_tri.ready follows that same step enable.
module triangle_unit_normal #(
    parameter int COORD_WIDTH      = tun_pkg::COORD_WIDTH,
    parameter int NORMAL_FRAC_BITS = tun_pkg::NORMAL_FRAC_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tun_in_if.sink    i_tri,
    tun_out_if.source o_nrm
);
    localparam int NB  = tun_pkg::NORM_BITS;
    localparam int RB  = NB + 1;
    localparam int SDW = 3 * NB + 4;

    tun_pkg::t_ctl w_ctl;

    // front: edges, cross product, magnitudes, normalise, squared length
    logic              w_f_vld;
    logic [2*NB+1:0]   w_f_sum;
    logic [3*NB-1:0]   w_f_s;
    logic [2:0]        w_f_neg;
    logic              w_f_deg;

    // root pipe carries the scaled components alongside
    logic              w_r_vld;
    logic [RB-1:0]     w_r_root;
    logic [SDW-1:0]    w_r_side;

    logic              w_d_vld;

    // single step enable: advance unless the output word is stuck
    assign w_ctl.en    = !w_d_vld || o_nrm.ready;
    // no word is taken while reset clears the valid bits
    assign i_tri.ready = w_ctl.en && i_rst_n;
    assign o_nrm.valid = w_d_vld;

    tun_front #(
        .CW (COORD_WIDTH),
        .NB (NB)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_vld   (i_tri.valid),
        .i_a_x   (i_tri.a_x),
        .i_a_y   (i_tri.a_y),
        .i_a_z   (i_tri.a_z),
        .i_b_x   (i_tri.b_x),
        .i_b_y   (i_tri.b_y),
        .i_b_z   (i_tri.b_z),
        .i_c_x   (i_tri.c_x),
        .i_c_y   (i_tri.c_y),
        .i_c_z   (i_tri.c_z),
        .o_vld   (w_f_vld),
        .o_sum   (w_f_sum),
        .o_s     (w_f_s),
        .o_neg   (w_f_neg),
        .o_deg   (w_f_deg)
    );

    tun_sqrt #(
        .RB  (RB),
        .SDW (SDW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_vld   (w_f_vld),
        .i_n     (w_f_sum),
        .i_side  ({w_f_deg, w_f_neg, w_f_s}),
        .o_vld   (w_r_vld),
        .o_root  (w_r_root),
        .o_side  (w_r_side)
    );

    // rounded divide of each component by the length, then sign and zero-area override
    tun_div #(
        .NB (NB),
        .F  (NORMAL_FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_vld   (w_r_vld),
        .i_root  (w_r_root),
        .i_s     (w_r_side[3*NB-1:0]),
        .i_neg   (w_r_side[3*NB+2:3*NB]),
        .i_deg   (w_r_side[3*NB+3]),
        .o_vld   (w_d_vld),
        .o_nx    (o_nrm.normal_x),
        .o_ny    (o_nrm.normal_y),
        .o_nz    (o_nrm.normal_z),
        .o_deg   (o_nrm.degenerate)
    );
endmodule

>>> src/tun_front.sv
module tun_front #(
    parameter int CW = tun_pkg::COORD_WIDTH,
    parameter int NB = tun_pkg::NORM_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tun_pkg::t_ctl        i_ctl,
    input  logic                 i_vld,
    input  logic signed [CW-1:0] i_a_x, i_a_y, i_a_z,
    input  logic signed [CW-1:0] i_b_x, i_b_y, i_b_z,
    input  logic signed [CW-1:0] i_c_x, i_c_y, i_c_z,
    output logic                 o_vld,
    output logic [2*NB+1:0]      o_sum,
    output logic [3*NB-1:0]      o_s,
    output logic [2:0]           o_neg,
    output logic                 o_deg
);
    localparam int EW  = CW + 1;
    localparam int PW  = 2 * EW;
    localparam int XW  = PW + 1;
    localparam int LZW = $clog2(XW + 1);
    localparam int SW  = 2 * NB + 2;
    localparam int QW  = 2 * NB;

    logic [7:0] r_v;

    logic signed [EW-1:0] r_e1x, r_e1y, r_e1z, r_e2x, r_e2y, r_e2z;
    logic signed [PW-1:0] r_p [6];
    logic signed [XW-1:0] r_c [3];
    logic [XW-1:0]        r_m [3];
    logic [XW-1:0]        r_m5 [3];
    logic [LZW-1:0]       r_lz;
    logic [NB-1:0]        r_s6 [3];
    logic [NB-1:0]        r_s7 [3];
    logic [NB-1:0]        r_s8 [3];
    logic [QW-1:0]        r_sq [3];
    logic [SW-1:0]        r_sum;
    logic [2:0]           r_neg4, r_neg5, r_neg6, r_neg7, r_neg8;
    logic                 r_deg5, r_deg6, r_deg7, r_deg8;

    logic [XW-1:0]    w_or;
    logic [LZW-1:0]   w_lz;
    logic [XW+NB-1:0] w_x [3];

    // leading-zero count of the widest magnitude
    always_comb begin
        w_or = r_m[0] | r_m[1] | r_m[2];
        w_lz = LZW'(XW);
        for (int i = 0; i < XW; i++) begin
            if (w_or[i]) w_lz = LZW'(XW - 1 - i);
        end
        for (int k = 0; k < 3; k++) begin
            w_x[k] = {r_m5[k], NB'(0)} << r_lz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_ctl.en) begin
            r_v <= {r_v[6:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            // edges from the first vertex
            r_e1x <= EW'(i_b_x) - EW'(i_a_x);
            r_e1y <= EW'(i_b_y) - EW'(i_a_y);
            r_e1z <= EW'(i_b_z) - EW'(i_a_z);
            r_e2x <= EW'(i_c_x) - EW'(i_a_x);
            r_e2y <= EW'(i_c_y) - EW'(i_a_y);
            r_e2z <= EW'(i_c_z) - EW'(i_a_z);
            // cross product terms
            r_p[0] <= PW'(r_e1y) * PW'(r_e2z);
            r_p[1] <= PW'(r_e1z) * PW'(r_e2y);
            r_p[2] <= PW'(r_e1z) * PW'(r_e2x);
            r_p[3] <= PW'(r_e1x) * PW'(r_e2z);
            r_p[4] <= PW'(r_e1x) * PW'(r_e2y);
            r_p[5] <= PW'(r_e1y) * PW'(r_e2x);
            for (int k = 0; k < 3; k++) begin
                r_c[k]  <= XW'(r_p[2*k]) - XW'(r_p[2*k+1]);
                r_m[k]  <= r_c[k][XW-1] ? XW'(-r_c[k]) : XW'(r_c[k]);
                r_neg4[k] <= r_c[k][XW-1];
                r_m5[k] <= r_m[k];
                r_s6[k] <= w_x[k][XW+NB-1 -: NB];
                r_s7[k] <= r_s6[k];
                r_sq[k] <= QW'(r_s6[k]) * QW'(r_s6[k]);
                r_s8[k] <= r_s7[k];
            end
            r_lz   <= w_lz;
            r_neg5 <= r_neg4;
            r_deg5 <= (w_or == '0);
            r_neg6 <= r_neg5;
            r_deg6 <= r_deg5;
            r_neg7 <= r_neg6;
            r_deg7 <= r_deg6;
            r_sum  <= SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]);
            r_neg8 <= r_neg7;
            r_deg8 <= r_deg7;
        end
    end

    assign o_vld = r_v[7];
    assign o_sum = r_sum;
    assign o_s   = {r_s8[2], r_s8[1], r_s8[0]};
    assign o_neg = r_neg8;
    assign o_deg = r_deg8;
endmodule

>>> src/tun_sqrt.sv
module tun_sqrt #(
    parameter int RB  = tun_pkg::NORM_BITS + 1,
    parameter int SDW = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tun_pkg::t_ctl   i_ctl,
    input  logic            i_vld,
    input  logic [2*RB-1:0] i_n,
    input  logic [SDW-1:0]  i_side,
    output logic            o_vld,
    output logic [RB-1:0]   o_root,
    output logic [SDW-1:0]  o_side
);
    localparam int RW = RB + 3;

    logic [RB-1:0]   r_v;
    logic [2*RB-1:0] r_n [RB];
    logic [RW-1:0]   r_r [RB];
    logic [RB-1:0]   r_q [RB];
    logic [SDW-1:0]  r_side [RB];

    // one root bit per stage, restoring form
    for (genvar g = 0; g < RB; g++) begin : g_stage
        logic            w_pv;
        logic [2*RB-1:0] w_pn;
        logic [RW-1:0]   w_pr, w_rin, w_t;
        logic [RB-1:0]   w_pq;
        logic [SDW-1:0]  w_ps;

        if (g == 0) begin : g_first
            assign w_pv = i_vld;
            assign w_pn = i_n;
            assign w_pr = '0;
            assign w_pq = '0;
            assign w_ps = i_side;
        end else begin : g_next
            assign w_pv = r_v[g-1];
            assign w_pn = r_n[g-1];
            assign w_pr = r_r[g-1];
            assign w_pq = r_q[g-1];
            assign w_ps = r_side[g-1];
        end

        assign w_rin = {w_pr[RW-3:0], w_pn[2*RB-1 -: 2]};
        assign w_t   = {1'b0, w_pq, 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_ctl.en) begin
                r_v[g] <= w_pv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_n[g]    <= {w_pn[2*RB-3:0], 2'b00};
                r_side[g] <= w_ps;
                if (w_rin >= w_t) begin
                    r_r[g] <= w_rin - w_t;
                    r_q[g] <= {w_pq[RB-2:0], 1'b1};
                end else begin
                    r_r[g] <= w_rin;
                    r_q[g] <= {w_pq[RB-2:0], 1'b0};
                end
            end
        end
    end

    assign o_vld  = r_v[RB-1];
    assign o_root = r_q[RB-1];
    assign o_side = r_side[RB-1];
endmodule

>>> src/tun_div.sv
module tun_div #(
    parameter int NB = tun_pkg::NORM_BITS,
    parameter int F  = tun_pkg::NORMAL_FRAC_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tun_pkg::t_ctl       i_ctl,
    input  logic                i_vld,
    input  logic [NB:0]         i_root,
    input  logic [3*NB-1:0]     i_s,
    input  logic [2:0]          i_neg,
    input  logic                i_deg,
    output logic                o_vld,
    output logic signed [F+1:0] o_nx,
    output logic signed [F+1:0] o_ny,
    output logic signed [F+1:0] o_nz,
    output logic                o_deg
);
    localparam int NUW = NB + F + 2;
    localparam int DW  = NB + F + 3;
    localparam int QW  = F + 1;
    localparam int OW  = F + 2;

    // set-up stage
    logic           r_pv;
    logic [NUW-1:0] r_pnum [3];
    logic [DW-1:0]  r_pd;
    logic [2:0]     r_pneg;
    logic           r_pdeg;

    logic [QW-1:0]  r_v;
    logic [NUW-1:0] r_rem [QW][3];
    logic [QW-1:0]  r_q   [QW][3];
    logic [DW-1:0]  r_d   [QW];
    logic [2:0]     r_neg [QW];
    logic           r_deg [QW];

    logic                  r_ov;
    logic signed [OW-1:0]  r_o [3];
    logic                  r_odeg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_ov <= 1'b0;
        end else if (i_ctl.en) begin
            r_pv <= i_vld;
            r_ov <= r_v[QW-1];
        end
    end

    // numerator s*2^(F+1) + r, divisor 2r
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            for (int k = 0; k < 3; k++) begin
                r_pnum[k] <= NUW'({i_s[k*NB +: NB], QW'(0)}) + NUW'(i_root);
            end
            r_pd   <= DW'({i_root, 1'b0});
            r_pneg <= i_neg;
            r_pdeg <= i_deg;
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar g = 0; g < QW; g++) begin : g_stage
        logic           w_pv;
        logic [NUW-1:0] w_prem [3];
        logic [QW-1:0]  w_pq   [3];
        logic [DW-1:0]  w_pd, w_cmp;
        logic [2:0]     w_pneg;
        logic           w_pdeg;

        if (g == 0) begin : g_first
            assign w_pv   = r_pv;
            assign w_prem = r_pnum;
            assign w_pq   = '{default: '0};
            assign w_pd   = r_pd;
            assign w_pneg = r_pneg;
            assign w_pdeg = r_pdeg;
        end else begin : g_next
            assign w_pv   = r_v[g-1];
            assign w_prem = r_rem[g-1];
            assign w_pq   = r_q[g-1];
            assign w_pd   = r_d[g-1];
            assign w_pneg = r_neg[g-1];
            assign w_pdeg = r_deg[g-1];
        end

        assign w_cmp = w_pd << (F - g);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_ctl.en) begin
                r_v[g] <= w_pv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                for (int k = 0; k < 3; k++) begin
                    if (DW'(w_prem[k]) >= w_cmp) begin
                        r_rem[g][k] <= NUW'(DW'(w_prem[k]) - w_cmp);
                        r_q[g][k]   <= {w_pq[k][QW-2:0], 1'b1};
                    end else begin
                        r_rem[g][k] <= w_prem[k];
                        r_q[g][k]   <= {w_pq[k][QW-2:0], 1'b0};
                    end
                end
                r_d[g]   <= w_pd;
                r_neg[g] <= w_pneg;
                r_deg[g] <= w_pdeg;
            end
        end
    end

    // sign and zero-area override
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            for (int k = 0; k < 3; k++) begin
                if (r_deg[QW-1]) begin
                    r_o[k] <= '0;
                end else if (r_neg[QW-1][k]) begin
                    r_o[k] <= -OW'(r_q[QW-1][k]);
                end else begin
                    r_o[k] <= OW'(r_q[QW-1][k]);
                end
            end
            r_odeg <= r_deg[QW-1];
        end
    end

    assign o_vld = r_ov;
    assign o_nx  = r_o[0];
    assign o_ny  = r_o[1];
    assign o_nz  = r_o[2];
    assign o_deg = r_odeg;
endmodule

>>> bench/triangle_unit_normal_tb.sv
module triangle_unit_normal_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW  = tun_pkg::COORD_WIDTH;
    localparam int FB  = tun_pkg::NORMAL_FRAC_BITS;
    localparam int NW  = FB + 2;
    localparam int NORM_BITS = tun_pkg::NORM_BITS;
    // pipe depth summed over the front, root and divide sections
    localparam int PIPE_DEPTH = 8 + (NORM_BITS + 1) + FB + 3;

    typedef struct {
        logic signed [CW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
    } t_tri;

    typedef struct {
        logic signed [NW-1:0] nx, ny, nz;
        logic                 degen;
    } t_nrm;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tun_in_if  #(.CoordWidth(CW)) tri_ch ();
    tun_out_if #(.FracBits(FB))   nrm_ch ();

    triangle_unit_normal #(
        .COORD_WIDTH(CW),
        .NORMAL_FRAC_BITS(FB)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_tri  (tri_ch.sink),
        .o_nrm  (nrm_ch.source)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    t_tri pending_tris[$];
    t_nrm expected_normals[$];
    int   n_errors = 0;
    bit   hold_off_req = 1'b0;   // long receiver stall requested by stimulus

    // ---------------------------------------------------------------
    // Predictor: exact cross product, scale so largest magnitude sits
    // in [2^30, 2^31), integer square root, rounded divide.
    // ---------------------------------------------------------------
    function automatic longint unsigned isqrt_u64(longint unsigned n);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic t_nrm face_normal(t_tri t);
        logic signed [CW:0]       e1x, e1y, e1z, e2x, e2y, e2z;
        logic signed [2*CW+3:0]   cr[3];
        logic        [2*CW+3:0]   mg[3];
        longint unsigned          sc[3];
        longint unsigned          sum, root, q;
        int                       len, l;
        t_nrm                     res;
        e1x = t.bx - t.ax; e1y = t.by - t.ay; e1z = t.bz - t.az;
        e2x = t.cx - t.ax; e2y = t.cy - t.ay; e2z = t.cz - t.az;
        cr[0] = e1y * e2z - e1z * e2y;
        cr[1] = e1z * e2x - e1x * e2z;
        cr[2] = e1x * e2y - e1y * e2x;
        len = 0;
        for (int i = 0; i < 3; i++) begin
            mg[i] = cr[i] < 0 ? -cr[i] : cr[i];
            l = 0;
            for (int b = 0; b < 2*CW+4; b++) if (mg[i][b]) l = b + 1;
            if (l > len) len = l;
        end
        if (len == 0) begin
            res.nx = '0; res.ny = '0; res.nz = '0; res.degen = 1'b1;
            return res;
        end
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            if (len > NORM_BITS) sc[i] = 64'(mg[i] >> (len - NORM_BITS));
            else                 sc[i] = 64'(mg[i]) << (NORM_BITS - len);
            sum += sc[i] * sc[i];
        end
        root = isqrt_u64(sum);
        for (int i = 0; i < 3; i++) begin
            q = 0;
            if (root != 0) q = ((sc[i] << (FB + 1)) + root) / (root << 1);
            if (cr[i] < 0) q = -q;
            case (i)
                0: res.nx = q[NW-1:0];
                1: res.ny = q[NW-1:0];
                default: res.nz = q[NW-1:0];
            endcase
        end
        res.degen = 1'b0;
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    // ---------------------------------------------------------------
    // Driver: bursts of words, random gaps between bursts.
    // ---------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tri_ch.valid <= 1'b0;
        end else begin
            // word taken this edge
            if (tri_ch.valid && tri_ch.ready) begin
                expected_normals.push_back(face_normal(pending_tris.pop_front()));
            end
            if (!(tri_ch.valid && !tri_ch.ready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    tri_ch.valid <= 1'b0;
                end else if (pending_tris.size() > 0) begin
                    tri_ch.valid <= 1'b1;
                    tri_ch.a_x <= pending_tris[0].ax; tri_ch.a_y <= pending_tris[0].ay;
                    tri_ch.a_z <= pending_tris[0].az; tri_ch.b_x <= pending_tris[0].bx;
                    tri_ch.b_y <= pending_tris[0].by; tri_ch.b_z <= pending_tris[0].bz;
                    tri_ch.c_x <= pending_tris[0].cx; tri_ch.c_y <= pending_tris[0].cy;
                    tri_ch.c_z <= pending_tris[0].cz;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    tri_ch.valid <= 1'b0;
                end
            end
        end
    end

    // pending_tris is peeked by the driver before the pop on acceptance,
    // so the head always matches what sits on the bus.

    // ---------------------------------------------------------------
    // Receiver stall pattern, plus one long hold-off.
    // ---------------------------------------------------------------
    int stall_phase = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            nrm_ch.ready <= 1'b0;
        end else begin
            stall_phase = (stall_phase + 1) % 23;
            if (hold_off_req && !hold_done && hold_left == 0) begin
                hold_left = 3 * PIPE_DEPTH;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                nrm_ch.ready <= 1'b0;
            end else if (stall_phase < 8) begin
                nrm_ch.ready <= 1'b1;    // stretch with no stalls
            end else if (stall_phase < 14) begin
                nrm_ch.ready <= ($urandom_range(0, 3) != 0);
            end else begin
                nrm_ch.ready <= ($urandom_range(0, 1) != 0);
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: compare each taken word with the oldest prediction.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_nrm want;
        if (i_rst_n && nrm_ch.valid && nrm_ch.ready) begin
            if (expected_normals.size() == 0) begin
                report_mismatch("unexpected word", 0, 0);
            end else begin
                want = expected_normals.pop_front();
                if (nrm_ch.normal_x !== want.nx)
                    report_mismatch("normal_x", nrm_ch.normal_x, want.nx);
                if (nrm_ch.normal_y !== want.ny)
                    report_mismatch("normal_y", nrm_ch.normal_y, want.ny);
                if (nrm_ch.normal_z !== want.nz)
                    report_mismatch("normal_z", nrm_ch.normal_z, want.nz);
                if (nrm_ch.degenerate !== want.degen)
                    report_mismatch("degenerate", nrm_ch.degenerate, want.degen);
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            1: return CW'($signed($urandom_range(0, 16)) - 8);     // tiny
            default: return CW'($urandom);
        endcase
    endfunction

    task automatic add_tri(int ax, int ay, int az, int bx, int by, int bz,
                           int cx, int cy, int cz);
        t_tri t;
        t.ax = CW'(ax); t.ay = CW'(ay); t.az = CW'(az);
        t.bx = CW'(bx); t.by = CW'(by); t.bz = CW'(bz);
        t.cx = CW'(cx); t.cy = CW'(cy); t.cz = CW'(cz);
        pending_tris.push_back(t);
    endtask

    initial begin
        t_tri t;
        int   k;
        tri_ch.valid = 1'b0;
        tri_ch.a_x = '0; tri_ch.a_y = '0; tri_ch.a_z = '0;
        tri_ch.b_x = '0; tri_ch.b_y = '0; tri_ch.b_z = '0;
        tri_ch.c_x = '0; tri_ch.c_y = '0; tri_ch.c_z = '0;
        nrm_ch.ready = 1'b0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: axis-aligned faces, the z face in both windings
        add_tri(0, 0, 0, 256, 0, 0, 0, 256, 0);
        add_tri(0, 0, 0, 0, 256, 0, 256, 0, 0);
        add_tri(0, 0, 0, 0, 256, 0, 0, 0, 256);
        add_tri(0, 0, 0, 0, 0, 256, 256, 0, 0);
        // zero area: all same point, collinear, repeated vertex
        add_tri(0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_tri(100, 200, 300, 200, 400, 600, 300, 600, 900);
        add_tri(-32768, 5, 7, -32768, 5, 7, 32767, 1, 2);
        // extremes: widest edges, largest cross product
        add_tri(-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768);
        add_tri(32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768, -32768);
        add_tri(-32768, 32767, -32768, 32767, -32768, 32767, -32768, -32768, 32767);
        add_tri(32767, -32768, 32767, -32768, 32767, 32767, 32767, 32767, -32768);
        // smallest non-zero cross product (needs left scaling)
        add_tri(0, 0, 0, 1, 0, 0, 0, 1, 0);
        add_tri(-1, -1, -1, 0, -1, -1, -1, -1, 0);
        // diagonal faces with all components of equal magnitude, then a general face
        add_tri(256, 0, 0, 0, 256, 0, 0, 0, 256);
        add_tri(-256, 0, 0, 0, -256, 0, 0, 0, -256);
        add_tri(1, 2, 3, -4, 5, -6, 7, -8, 9);

        // random: mostly general triangles, some degenerate, some sliver
        for (int n = 0; n < 1700; n++) begin
            t.ax = rand_coord(); t.ay = rand_coord(); t.az = rand_coord();
            t.bx = rand_coord(); t.by = rand_coord(); t.bz = rand_coord();
            t.cx = rand_coord(); t.cy = rand_coord(); t.cz = rand_coord();
            k = $urandom_range(0, 19);
            if (k == 0) begin
                t.cx = t.ax; t.cy = t.ay; t.cz = t.az;            // repeated vertex
            end else if (k == 1) begin
                t.bx = t.ax; t.by = t.ay; t.bz = t.az;
            end else if (k == 2) begin
                // collinear: C = A + 2 (B - A) on small offsets
                t.bx = t.ax + CW'($signed($urandom_range(0, 200)) - 100);
                t.by = t.ay + CW'($signed($urandom_range(0, 200)) - 100);
                t.bz = t.az + CW'($signed($urandom_range(0, 200)) - 100);
                t.cx = t.bx + (t.bx - t.ax);
                t.cy = t.by + (t.by - t.ay);
                t.cz = t.bz + (t.bz - t.az);
            end else if (k == 3) begin
                // sliver: near-degenerate small edges
                t.bx = t.ax + CW'($urandom_range(0, 3));
                t.by = t.ay + CW'($urandom_range(0, 3));
                t.bz = t.az;
                t.cx = t.ax; t.cy = t.ay + CW'($urandom_range(0, 2));
                t.cz = t.az + CW'($urandom_range(0, 2));
            end
            pending_tris.push_back(t);
            if (n == 400) begin
                // let the pipe fill behind a long receiver stall
                wait (pending_tris.size() < 50);
                hold_off_req = 1'b1;
            end
        end

        wait (pending_tris.size() == 0 && !tri_ch.valid);
        wait (expected_normals.size() == 0);
        repeat (PIPE_DEPTH + 20) @(posedge i_clk);

        if (n_errors == 0 && expected_normals.size() == 0) begin
            $display("triangle_unit_normal_tb: PASS");
        end else begin
            $display("triangle_unit_normal_tb: FAIL");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2ms;
        $display("triangle_unit_normal_tb: FAIL");
        $finish;
    end

endmodule
